@@ src/spd_pkg.sv @@
// Shared constants and types for the slot presence detector.
package spd_pkg;

    // Width of the slot fields carried on the ports
    localparam int FIELD_SLOTS    = 16;
    localparam int NUM_SLOTS_DEF  = 16;
    localparam int WINDOW_LEN_DEF = 8;

    localparam int THR_W   = 4;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_SLOT_ENABLE = 1'b0;
    localparam logic REG_THRESHOLD   = 1'b1;

    localparam logic [FIELD_SLOTS-1:0] SLOT_ENABLE_RST = 16'hFFFF;
    localparam logic [THR_W-1:0]       THRESHOLD_RST   = 4'd6;

    typedef logic [1:0] t_slot_state;

    localparam t_slot_state ST_OFFLINE = 2'd0;
    localparam t_slot_state ST_WAKING  = 2'd1;
    localparam t_slot_state ST_ONLINE  = 2'd2;

    // Per-beat control broadcast to every lane
    typedef struct packed {
        logic             step;
        logic [THR_W-1:0] threshold;
    } t_lane_ctl;

endpackage

@@ src/spd_lane.sv @@
// One slot lane: valid history, running count and presence state.
module spd_lane #(
    parameter int WINDOW_LEN = spd_pkg::WINDOW_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spd_pkg::t_lane_ctl  i_ctl,
    input  logic                i_bit,
    output spd_pkg::t_slot_state o_next_state
);
    import spd_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

    logic [WINDOW_LEN-1:0] r_window, n_window;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_missed, n_missed;
    t_slot_state           r_state, n_state;
    logic                  at_thr;

    always_comb begin
        n_window = WINDOW_LEN'({r_window, i_bit});
        // running count: new bit in, oldest bit out
        n_count  = r_count + CNT_W'(i_bit) - CNT_W'(r_window[WINDOW_LEN-1]);
        at_thr   = CMP_W'(n_count) >= CMP_W'(i_ctl.threshold);
        n_missed = r_missed;
        if (r_missed && i_bit) begin
            n_state  = ST_WAKING;
            n_missed = 1'b0;
        end else if (r_state == ST_WAKING) begin
            n_state = ST_ONLINE;
        end else begin
            n_state = at_thr ? ST_ONLINE : ST_OFFLINE;
            if (r_state == ST_ONLINE && !i_bit) begin
                n_missed = 1'b1;
            end
            if (!at_thr) begin
                n_missed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_count  <= '0;
            r_missed <= 1'b0;
            r_state  <= ST_OFFLINE;
        end else if (i_ctl.step) begin
            r_window <= n_window;
            r_count  <= n_count;
            r_missed <= n_missed;
            r_state  <= n_state;
        end
    end

    assign o_next_state = n_state;

endmodule

@@ src/spd_merge.sv @@
// Packs the lane states into one result beat, with output register and skid stage.
module spd_merge #(
    parameter int LANES = spd_pkg::FIELD_SLOTS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_step,
    input  spd_pkg::t_slot_state [LANES-1:0]       i_lane_state,
    input  logic [spd_pkg::FIELD_SLOTS-1:0]        i_slot_enable,
    output logic                                   o_in_ready,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [2*spd_pkg::FIELD_SLOTS-1:0]      o_slot_states,
    output logic [spd_pkg::FIELD_SLOTS-1:0]        o_alive_mask
);
    import spd_pkg::*;

    logic [2*FIELD_SLOTS-1:0] n_states, r_out_states, r_skid_states;
    logic [FIELD_SLOTS-1:0]   n_alive, r_out_alive, r_skid_alive;
    logic                     r_out_valid, r_skid_valid;
    logic                     pop;

    always_comb begin
        n_states = '0;
        n_alive  = '0;
        for (int s = 0; s < LANES; s++) begin
            n_states[2*s +: 2] = i_lane_state[s];
            n_alive[s]         = (i_lane_state[s] == ST_ONLINE) & i_slot_enable[s];
        end
    end

    assign pop = r_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_states <= r_skid_states;
                r_out_alive  <= r_skid_alive;
                r_skid_valid <= 1'b0;
            end
        end else if (i_step) begin
            if (!r_out_valid || pop) begin
                r_out_states <= n_states;
                r_out_alive  <= n_alive;
                r_out_valid  <= 1'b1;
            end else begin
                r_skid_states <= n_states;
                r_skid_alive  <= n_alive;
                r_skid_valid  <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready    = !r_skid_valid;
    assign o_out_valid   = r_out_valid;
    assign o_slot_states = r_out_states;
    assign o_alive_mask  = r_out_alive;

endmodule

@@ src/slot_presence_detector_unit.sv @@
// Slot presence detector: per-slot lanes, result merge and configuration registers.
// Each result beat is registered in the merge output register, or in its skid stage.
// One beat per cycle while o_in_ready is high; each lane: one add and compare per beat.
// A two-entry output buffer lets one more beat in while a result waits on i_out_ready.
// Synchronous active-low reset clears all slot history to OFFLINE, slot_enable to
// 0xFFFF and online_threshold to 6; no clearing pass, input ready right after reset.
module slot_presence_detector_unit #(
    parameter int NUM_SLOTS  = spd_pkg::NUM_SLOTS_DEF,
    parameter int WINDOW_LEN = spd_pkg::WINDOW_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [spd_pkg::FIELD_SLOTS-1:0]     i_slot_valid,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2*spd_pkg::FIELD_SLOTS-1:0]   o_slot_states,
    output logic [spd_pkg::FIELD_SLOTS-1:0]     o_alive_mask,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spd_pkg::APB_AW-1:0]          paddr,
    input  logic [spd_pkg::APB_DW-1:0]          pwdata,
    output logic [spd_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import spd_pkg::*;

    // slots past the port width never see a valid bit and are not reported
    localparam int LANES = (NUM_SLOTS < FIELD_SLOTS) ? NUM_SLOTS : FIELD_SLOTS;

    logic [FIELD_SLOTS-1:0]    r_slot_enable;
    logic [THR_W-1:0]          r_threshold;
    logic                      cfg_wr;
    logic                      reg_sel;
    logic                      step;
    t_lane_ctl                 lane_ctl;
    t_slot_state [LANES-1:0]   lane_state;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_enable <= SLOT_ENABLE_RST;
            r_threshold   <= THRESHOLD_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_SLOT_ENABLE: r_slot_enable <= pwdata[FIELD_SLOTS-1:0];
                REG_THRESHOLD:   r_threshold   <= pwdata[THR_W-1:0];
                default:         r_threshold   <= r_threshold;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SLOT_ENABLE: prdata = APB_DW'(r_slot_enable);
            REG_THRESHOLD:   prdata = APB_DW'(r_threshold);
            default:         prdata = '0;
        endcase
    end

    assign step               = i_in_valid & o_in_ready;
    assign lane_ctl.step      = step;
    assign lane_ctl.threshold = r_threshold;

    for (genvar s = 0; s < LANES; s++) begin : g_lane
        spd_lane #(
            .WINDOW_LEN (WINDOW_LEN)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (lane_ctl),
            .i_bit        (i_slot_valid[s] & r_slot_enable[s]),
            .o_next_state (lane_state[s])
        );
    end

    spd_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_lane_state  (lane_state),
        .i_slot_enable (r_slot_enable),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_slot_states (o_slot_states),
        .o_alive_mask  (o_alive_mask)
    );

endmodule

@@ src/spd_checker.sv @@
// Port-level checks for the slot presence detector, bound to the top level.
module spd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [2*spd_pkg::FIELD_SLOTS-1:0] o_slot_states,
    input logic [spd_pkg::FIELD_SLOTS-1:0]   o_alive_mask
);
    import spd_pkg::*;

    logic [FIELD_SLOTS-1:0] online_vec, waking_vec, bad_vec;
    logic [FIELD_SLOTS-1:0] r_prev_waking;
    logic                   r_have_prev;
    logic                   out_beat;

    always_comb begin
        for (int s = 0; s < FIELD_SLOTS; s++) begin
            online_vec[s] = o_slot_states[2*s +: 2] == ST_ONLINE;
            waking_vec[s] = o_slot_states[2*s +: 2] == ST_WAKING;
            bad_vec[s]    = o_slot_states[2*s +: 2] > ST_ONLINE;
        end
    end

    assign out_beat = o_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (out_beat) begin
            r_have_prev   <= 1'b1;
            r_prev_waking <= waking_vec;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_slot_states) && $stable(o_alive_mask))
        else $error("stalled result beat changed");

    a_alive_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_alive_mask & ~online_vec) == '0) && (bad_vec == '0))
        else $error("alive slot not online, or unused state code");

    // a waking slot must be online in the very next result beat
    a_wake_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_have_prev |-> ((r_prev_waking & ~online_vec) == '0))
        else $error("waking slot not online on next beat");

endmodule

bind slot_presence_detector_unit spd_checker u_spd_checker (.*);

@@ tb/sv/tb_slot_presence_detector_unit.sv @@
// Self-checking testbench for the slot presence detector: exchanges, APB setup, result checks.
`timescale 1ns / 100ps

module tb_slot_presence_detector_unit;
    import spd_pkg::*;

    localparam int LONG_HOLD = 300;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 215;

    typedef struct packed {
        logic [2*FIELD_SLOTS-1:0] states;
        logic [FIELD_SLOTS-1:0]   alive;
    } t_presence;

    // Tracks per-slot history and state; queues the expected result of each exchange.
    class presence_scoreboard;
        logic [WINDOW_LEN_DEF-1:0] history [NUM_SLOTS_DEF];
        bit                        missed  [NUM_SLOTS_DEF];
        t_slot_state               state   [NUM_SLOTS_DEF];
        logic [FIELD_SLOTS-1:0]    enable_mask;
        logic [THR_W-1:0]          threshold;
        t_presence                 expected_q [$];
        int                        errors;

        function new();
            enable_mask = SLOT_ENABLE_RST;
            threshold   = THRESHOLD_RST;
            errors      = 0;
            for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
                history[s] = '0;
                missed[s]  = 1'b0;
                state[s]   = ST_OFFLINE;
            end
        endfunction

        function void note_exchange(logic [FIELD_SLOTS-1:0] slot_valid);
            logic [FIELD_SLOTS-1:0] seen;
            t_presence              res;
            t_slot_state            nxt;
            logic                   b;
            int                     ones;
            seen = slot_valid & enable_mask;
            res  = '0;
            for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
                b = (s < FIELD_SLOTS) ? seen[s] : 1'b0;
                history[s] = {history[s][WINDOW_LEN_DEF-2:0], b};
                ones = $countones(history[s]);
                if (missed[s] && b) begin
                    nxt = ST_WAKING;
                    missed[s] = 1'b0;
                end else if (state[s] == ST_WAKING) begin
                    nxt = ST_ONLINE;
                end else begin
                    nxt = (ones >= int'(threshold)) ? ST_ONLINE : ST_OFFLINE;
                    if (state[s] == ST_ONLINE && !b) missed[s] = 1'b1;
                    if (nxt == ST_OFFLINE) missed[s] = 1'b0;
                end
                state[s] = nxt;
                if (s < FIELD_SLOTS) begin
                    res.states[2*s +: 2] = nxt;
                    if (nxt == ST_ONLINE) res.alive[s] = 1'b1;
                end
            end
            res.alive &= enable_mask;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [2*FIELD_SLOTS-1:0] states,
                                   logic [FIELD_SLOTS-1:0] alive);
            t_presence exp_r;
            if (expected_q.size() == 0) begin
                $error("result beat with no exchange pending: slot_states=%h alive_mask=%h",
                       states, alive);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (states !== exp_r.states) begin
                $error("slot_states: expected %h, got %h", exp_r.states, states);
                errors++;
            end
            if (alive !== exp_r.alive) begin
                $error("alive_mask: expected %h, got %h", exp_r.alive, alive);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [FIELD_SLOTS-1:0]   i_slot_valid = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b1;
    logic [2*FIELD_SLOTS-1:0] o_slot_states;
    logic [FIELD_SLOTS-1:0]   o_alive_mask;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    presence_scoreboard       sb;
    logic [FIELD_SLOTS-1:0]   present_mask = 16'h0F3C;
    bit                       hold_req = 1'b0;

    slot_presence_detector_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_slot_valid  (i_slot_valid),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_slot_states (o_slot_states),
        .o_alive_mask  (o_alive_mask),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_exchange(i_slot_valid);
            if (o_out_valid && i_out_ready) sb.check_result(o_slot_states, o_alive_mask);
        end
    end

    // Receiver: rotating stall pattern, or one long hold-off on request.
    initial begin
        logic [15:0] pattern;
        int          pos;
        pattern = '1;
        pos     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= pattern[pos];
                pos = (pos + 1) % 16;
                if (pos == 0) begin
                    case ($urandom_range(0, 3))
                        0: pattern = '1;
                        1: pattern = 16'($urandom);
                        2: pattern = 16'($urandom | $urandom);
                        default: pattern = 16'($urandom & $urandom);
                    endcase
                end
            end
        end
    end

    task automatic send_exchange(input logic [FIELD_SLOTS-1:0] v);
        i_in_valid   <= 1'b1;
        i_slot_valid <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic pause_sender(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending and wait until every queued result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // APB write followed by a read-back of the same register.
    task automatic reg_write(input logic reg_idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_idx == REG_SLOT_ENABLE) begin
            sb.enable_mask = value[FIELD_SLOTS-1:0];
            stored = APB_DW'(value[FIELD_SLOTS-1:0]);
        end else begin
            sb.threshold = value[THR_W-1:0];
            stored = APB_DW'(value[THR_W-1:0]);
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored) begin
            $error("prdata at %h: expected %h, got %h", {reg_idx, 2'b00}, stored, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly slots that come and go with occasional dropouts and stray bits; some pure noise.
    function automatic logic [FIELD_SLOTS-1:0] next_exchange();
        logic [FIELD_SLOTS-1:0] drop;
        logic [FIELD_SLOTS-1:0] stray;
        logic [FIELD_SLOTS-1:0] v;
        drop  = FIELD_SLOTS'($urandom & $urandom & $urandom);
        stray = FIELD_SLOTS'($urandom & $urandom & $urandom);
        if ($urandom_range(0, 9) == 0) v = FIELD_SLOTS'($urandom);
        else v = (present_mask & ~drop) | (~present_mask & stray);
        if ($urandom_range(0, 15) == 0) present_mask ^= 16'h1 << $urandom_range(0, 15);
        return v;
    endfunction

    task automatic run_random(input int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            for (int k = $urandom_range(1, 40); k > 0 && sent < n; k--) begin
                send_exchange(next_exchange());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        end
    endtask

    initial begin
        logic [15:0]      directed_items [22];
        logic [15:0]      phase_enable   [NUM_PHASES];
        logic [THR_W-1:0] phase_thr      [NUM_PHASES];
        logic [15:0]      en;
        directed_items = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFF00,
                           16'hFF00, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 16'h0000,
                           16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
        phase_enable   = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hA5C3,
                           16'h0000, 16'hFFFF, 16'h7FFE, 16'hFFFF};
        phase_thr      = '{4'd6, 4'd0, 4'd8, 4'd3, 4'd4, 4'd15, 4'd1, 4'd5};
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: reach online, miss one exchange, wake, back online
        foreach (directed_items[i]) send_exchange(directed_items[i]);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            en = (p == 6) ? 16'($urandom_range(0, 65535)) : phase_enable[p];
            reg_write(REG_SLOT_ENABLE, APB_DW'(en));
            reg_write(REG_THRESHOLD, APB_DW'(phase_thr[p]));
            send_exchange(16'h0000);
            send_exchange(16'hFFFF);
            run_random(PHASE_ITEMS / 2);
            if (p == 1) hold_req = 1'b1;  // receiver backs up, input must stall
            if (p == 4) drain();
            run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            drain();
        end

        repeat (5) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** slot_presence_detector_unit: PASSED **");
        end else begin
            $display("** slot_presence_detector_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** slot_presence_detector_unit: FAILED **");
        $finish;
    end

endmodule
